// File: src/iae_pkg.sv
// shared types and constants for the integer arithmetic encoder
// no dependencies
package iae_pkg;

  localparam int PREC          = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int PEND_W        = 16;
  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

  localparam int CL_W          = 6;
  localparam int CH_W          = 7;
  localparam int TC_W          = 7;
  localparam logic [TC_W-1:0] TC_RESET = 7'd64;

  // signed interval width times an unsigned count
  localparam int PROD_W        = PREC + 2 + CH_W + 1;

  // divide unit: 64-bit dividend, one byte of quotient bits per cycle
  localparam int DIV_W         = 64;
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;

  // request queue depth, power of two
  localparam int QDEPTH        = 2;

  typedef struct packed {
    logic [CL_W-1:0] cum_low;
    logic [CH_W-1:0] cum_high;
  } iae_in_t;

  typedef struct packed {
    logic              lead_bit;
    logic [PEND_W-1:0] follow_count;
    logic              last_of_run;
  } iae_out_t;

  typedef struct packed {
    iae_in_t item;
    logic    narrow_en;
  } iae_entry_t;

endpackage

// File: src/iae_front.sv
// front end: accepts requests, tags them and holds them in a short queue
// depends on iae_pkg
module iae_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  iae_pkg::iae_in_t            in_data,
  input  logic [iae_pkg::TC_W-1:0]    total_count,
  output logic                        q_valid,
  output iae_pkg::iae_entry_t         q_entry,
  input  logic                        q_pop
);

  localparam int PTR_W = $clog2(iae_pkg::QDEPTH);
  localparam int CNT_W = $clog2(iae_pkg::QDEPTH + 1);

  iae_pkg::iae_entry_t queue_r [iae_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  iae_pkg::iae_entry_t entry;

  assign in_stall = (cnt_r == CNT_W'(iae_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = queue_r[rd_ptr_r];

  // zero total skips narrowing
  always_comb begin
    entry.item      = in_data;
    entry.narrow_en = (total_count != '0);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// File: src/iae_div.sv
// two-lane restoring divider sharing one divisor, several quotient bits per cycle
// depends on iae_pkg
module iae_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [iae_pkg::DIV_W-1:0]     dividend_a,
  input  logic [iae_pkg::DIV_W-1:0]     dividend_b,
  input  logic [iae_pkg::TC_W-1:0]      divisor,
  output logic                          done,
  output logic [iae_pkg::PREC-1:0]      quot_a,
  output logic [iae_pkg::PREC-1:0]      quot_b
);

  localparam int CNT_W = $clog2(iae_pkg::DIV_CYCLES + 1);
  localparam int DW    = iae_pkg::DIV_W;
  localparam int RW    = iae_pkg::TC_W;
  localparam int QW    = iae_pkg::PREC;

  logic [DW-1:0]    num_a_r, num_b_r, num_a_nxt, num_b_nxt;
  logic [RW-1:0]    rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt;
  logic [QW-1:0]    quo_a_r, quo_b_r, quo_a_nxt, quo_b_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  always_comb begin
    logic [RW:0] ta;
    logic [RW:0] tb;
    logic        ga;
    logic        gb;
    num_a_nxt = num_a_r;
    num_b_nxt = num_b_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    quo_a_nxt = quo_a_r;
    quo_b_nxt = quo_b_r;
    for (int i = 0; i < iae_pkg::DIV_STEP_BITS; i++) begin
      ta = {rem_a_nxt, num_a_nxt[DW-1]};
      tb = {rem_b_nxt, num_b_nxt[DW-1]};
      num_a_nxt = {num_a_nxt[DW-2:0], 1'b0};
      num_b_nxt = {num_b_nxt[DW-2:0], 1'b0};
      ga = (ta >= {1'b0, divisor});
      gb = (tb >= {1'b0, divisor});
      if (ga) begin
        ta = ta - {1'b0, divisor};
      end
      if (gb) begin
        tb = tb - {1'b0, divisor};
      end
      rem_a_nxt = ta[RW-1:0];
      rem_b_nxt = tb[RW-1:0];
      quo_a_nxt = {quo_a_nxt[QW-2:0], ga};
      quo_b_nxt = {quo_b_nxt[QW-2:0], gb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(iae_pkg::DIV_CYCLES);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_a_r <= dividend_a;
      num_b_r <= dividend_b;
      rem_a_r <= '0;
      rem_b_r <= '0;
      quo_a_r <= '0;
      quo_b_r <= '0;
    end else if (cnt_r != '0) begin
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      quo_a_r <= quo_a_nxt;
      quo_b_r <= quo_b_nxt;
    end
  end

  assign done   = done_r;
  assign quot_a = quo_a_r;
  assign quot_b = quo_b_r;

endmodule

// File: src/iae_back.sv
// back end: renormalization sequencer, result output register and interval narrowing
// depends on iae_pkg and iae_div
module iae_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  iae_pkg::iae_entry_t         q_entry,
  output logic                        q_pop,
  input  logic [iae_pkg::TC_W-1:0]    total_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output iae_pkg::iae_out_t           out_data
);

  localparam int P      = iae_pkg::PREC;
  localparam int ITER_W = $clog2(iae_pkg::PREC + 1);
  localparam int N_W    = $clog2(iae_pkg::MAX_RESULTS + 1);
  localparam int PW     = iae_pkg::PROD_W;
  localparam int SW     = iae_pkg::PEND_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RENORM = 3'd1;
  localparam logic [2:0] S_FLUSH  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [P-1:0]               low_r, low_nxt;
  logic [P-1:0]               high_r, high_nxt;
  logic [SW-1:0]              pend_r, pend_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic [N_W-1:0]             n_r, n_nxt;
  logic                       held_v_r, held_v_nxt;
  iae_pkg::iae_out_t          held_r, held_nxt;
  logic [iae_pkg::CL_W-1:0]   cl_r, cl_nxt;
  logic [iae_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic                       narrow_r, narrow_nxt;
  logic signed [PW-1:0]       prod_a_r, prod_a_nxt;
  logic signed [PW-1:0]       prod_b_r, prod_b_nxt;
  logic                       out_valid_r, out_valid_nxt;
  iae_pkg::iae_out_t          out_data_r, out_data_nxt;

  logic                       push;
  iae_pkg::iae_out_t          push_data;
  logic                       out_free;
  logic                       div_start;
  logic                       div_done;
  logic [P-1:0]               quot_a;
  logic [P-1:0]               quot_b;
  logic signed [P+1:0]        width_s;
  logic signed [PW-1:0]       w_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign width_s  = $signed({2'b00, high_r}) - $signed({2'b00, low_r})
                  + $signed((P + 2)'(1));
  assign w_ext    = PW'(width_s);

  iae_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_a (iae_pkg::DIV_W'(prod_a_r)),
    .dividend_b (iae_pkg::DIV_W'(prod_b_r)),
    .divisor    (total_count),
    .done       (div_done),
    .quot_a     (quot_a),
    .quot_b     (quot_b)
  );

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    iter_nxt   = iter_r;
    n_nxt      = n_r;
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    cl_nxt     = cl_r;
    ch_nxt     = ch_r;
    narrow_nxt = narrow_r;
    prod_a_nxt = prod_a_r;
    prod_b_nxt = prod_b_r;
    push       = 1'b0;
    push_data  = held_r;
    q_pop      = 1'b0;
    div_start  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cl_nxt     = q_entry.item.cum_low;
          ch_nxt     = q_entry.item.cum_high;
          narrow_nxt = q_entry.narrow_en;
          iter_nxt   = '0;
          n_nxt      = '0;
          state_nxt  = S_RENORM;
        end
      end
      S_RENORM: begin
        if (iter_r == ITER_W'(P) || n_r == N_W'(iae_pkg::MAX_RESULTS)) begin
          state_nxt = S_FLUSH;
        end else if (high_r[P-1] == low_r[P-1]) begin
          // matching msb: earlier held result is not the last one
          if (!held_v_r || out_free) begin
            push                  = held_v_r;
            held_nxt.lead_bit     = high_r[P-1];
            held_nxt.follow_count = pend_r;
            held_nxt.last_of_run  = 1'b0;
            held_v_nxt            = 1'b1;
            pend_nxt              = '0;
            low_nxt               = {low_r[P-2:0], 1'b0};
            high_nxt              = {high_r[P-2:0], 1'b1};
            n_nxt                 = n_r + N_W'(1);
            iter_nxt              = iter_r + ITER_W'(1);
          end
        end else if (!high_r[P-2] && low_r[P-2]) begin
          // straddles the middle
          low_nxt  = {~low_r[P-2], low_r[P-3:0], 1'b0};
          high_nxt = {~high_r[P-2], high_r[P-3:0], 1'b1};
          if (pend_r != iae_pkg::PEND_MAX) begin
            pend_nxt = pend_r + SW'(1);
          end
          iter_nxt = iter_r + ITER_W'(1);
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (held_v_r) begin
          if (out_free) begin
            push                  = 1'b1;
            push_data.last_of_run = 1'b1;
            held_v_nxt            = 1'b0;
            state_nxt             = narrow_r ? S_MUL : S_IDLE;
          end
        end else begin
          state_nxt = narrow_r ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        prod_a_nxt = w_ext * PW'($signed({1'b0, ch_r}));
        prod_b_nxt = w_ext * PW'($signed({2'b00, cl_r}));
        state_nxt  = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          high_nxt  = low_r + quot_a - P'(1);
          low_nxt   = low_r + quot_b;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= '1;
      pend_r      <= '0;
      iter_r      <= '0;
      n_r         <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      pend_r      <= pend_nxt;
      iter_r      <= iter_nxt;
      n_r         <= n_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    cl_r       <= cl_nxt;
    ch_r       <= ch_nxt;
    narrow_r   <= narrow_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_W'(iae_pkg::MAX_RESULTS))
    else $error("result count past limit");

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !held_v_r)
    else $error("held result left behind at idle");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result overwrites undelivered output");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DWAIT)
    else $error("divider finished outside wait state");

endmodule

// File: src/integer_arithmetic_encoder_unit.sv
// integer arithmetic encoder with msb-match and middle-straddle renormalization
// results: one per msb-match shift in S_RENORM; the last one is pushed in S_FLUSH, marked last_of_run
// requests: the back end pops the next request from the queue only once it is back in idle,
//   paced by one renormalization shift per cycle (msb-match shifts wait while the output
//   stalls) and, with narrowing, by the 64-bit divider retiring 8 quotient bits per cycle
// reset (synchronous, rst_n low): bounds to 0 and all ones, pending to 0, total to 64
// depends on iae_pkg, iae_front, iae_back
module integer_arithmetic_encoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  iae_pkg::iae_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output iae_pkg::iae_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [iae_pkg::TC_W-1:0]  cfg_wdata
);

  logic [iae_pkg::TC_W-1:0] total_count_r;
  logic                     q_valid;
  iae_pkg::iae_entry_t      q_entry;
  logic                     q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_count_r <= iae_pkg::TC_RESET;
    end else if (cfg_we) begin
      total_count_r <= cfg_wdata;
    end
  end

  iae_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .total_count (total_count_r),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  iae_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .total_count (total_count_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
